/* hdl/mtat_pkg.sv */
`timescale 1ns / 1ps

package mtat_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int TURN_BITS  = 16;
    localparam int RAW_BITS   = 12;
    localparam int POS_BITS   = 29;
    localparam int EXT_BITS   = TURN_BITS + ANGLE_BITS + POS_BITS;

    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        ZONE_LOW  = 2'd1,
        ZONE_MID  = 2'd2,
        ZONE_HIGH = 2'd3
    } zone_t;

    typedef enum logic {
        OP_SAMPLE     = 1'b0,
        OP_SET_ORIGIN = 1'b1
    } op_t;

endpackage

/* hdl/mtat_in_if.sv */
`timescale 1ns / 1ps

interface mtat_in_if
    import mtat_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                op;
    logic [RAW_BITS-1:0] raw_angle;

    modport source (output valid, output op, output raw_angle, input ready);
    modport sink   (input valid, input op, input raw_angle, output ready);
endinterface

/* hdl/mtat_out_if.sv */
`timescale 1ns / 1ps

interface mtat_out_if
    import mtat_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] position;
    logic                       turn_saturated;

    modport source (output valid, output position, output turn_saturated, input ready);
    modport sink   (input valid, input position, input turn_saturated, output ready);
endinterface

/* hdl/multi_turn_angle_tracker_top.sv */
`timescale 1ns / 1ps

// Multi-turn angle tracker.
// sample: one word per sensor reading (op = 0, raw_angle) or an origin
//   request (op = 1, raw_angle ignored).
// result: one word per sample word: position relative to the origin in
//   units of 1/4096 revolution, and turn_saturated when the turn counter
//   sits at a limit.
// An accepted word is written to the result register at the accepting edge.
// Throughput is one word per cycle while results are taken, set by the
// single update stage between the sample port and the result register.
// sample.ready is high while the result register is empty or being taken
// in the same cycle, so a stalled receiver stalls the sender after one
// word; the result word holds until taken.
// Reset clears the zero angle, turn count, absolute position and origin; the first
// sample after reset becomes the zero angle.
module multi_turn_angle_tracker_top
    import mtat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mtat_in_if.sink    sample,
    mtat_out_if.source result
);

    logic [ANGLE_BITS-1:0]       zero_angle_reg, zero_angle_next;
    logic                        zero_taken_reg, zero_taken_next;
    zone_t                       prev_zone_reg, prev_zone_next;
    logic signed [TURN_BITS-1:0] turn_reg, turn_next;
    logic signed [POS_BITS-1:0]  abs_reg, abs_next;
    logic signed [POS_BITS-1:0]  origin_reg, origin_next;
    logic                        out_valid_reg;
    logic signed [POS_BITS-1:0]  position_reg, position_next;
    logic                        sat_reg, sat_next;

    logic                        accept;
    logic [ANGLE_BITS-1:0]       raw;
    logic [ANGLE_BITS-1:0]       offset;
    zone_t                       zone;
    logic signed [EXT_BITS-1:0]  turn_ext;
    logic signed [EXT_BITS-1:0]  abs_ext;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign raw          = ANGLE_BITS'(sample.raw_angle);

    always_comb
    begin
        zero_angle_next = zero_angle_reg;
        zero_taken_next = zero_taken_reg;
        prev_zone_next  = prev_zone_reg;
        turn_next       = turn_reg;
        abs_next        = abs_reg;
        origin_next     = origin_reg;
        offset          = raw - zero_angle_reg;
        zone            = ZONE_LOW;
        turn_ext        = '0;
        abs_ext         = '0;

        if (op_t'(sample.op) == OP_SET_ORIGIN)
        begin
            origin_next   = abs_reg;
            position_next = '0;
        end
        else
        begin
            if (!zero_taken_reg)
            begin
                zero_angle_next = raw;
                zero_taken_next = 1'b1;
                offset          = '0;
            end

            case (offset[ANGLE_BITS-1 -: 2])
                2'b00:   zone = ZONE_LOW;
                2'b11:   zone = ZONE_HIGH;
                default: zone = ZONE_MID;
            endcase

            if (prev_zone_reg == ZONE_HIGH && zone == ZONE_LOW && turn_reg != TURN_MAX)
            begin
                turn_next = turn_reg + TURN_BITS'(1);
            end
            else if (prev_zone_reg == ZONE_LOW && zone == ZONE_HIGH && turn_reg != TURN_MIN)
            begin
                turn_next = turn_reg - TURN_BITS'(1);
            end
            prev_zone_next = zone;

            turn_ext      = EXT_BITS'(turn_next);
            abs_ext       = (turn_ext <<< ANGLE_BITS) | EXT_BITS'(offset);
            abs_next      = abs_ext[POS_BITS-1:0];
            position_next = abs_next - origin_reg;
        end

        sat_next = (turn_next == TURN_MAX) || (turn_next == TURN_MIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_angle_reg <= '0;
            zero_taken_reg <= 1'b0;
            prev_zone_reg  <= ZONE_LOW;
            turn_reg       <= '0;
            abs_reg        <= '0;
            origin_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                zero_angle_reg <= zero_angle_next;
                zero_taken_reg <= zero_taken_next;
                prev_zone_reg  <= prev_zone_next;
                turn_reg       <= turn_next;
                abs_reg        <= abs_next;
                origin_reg     <= origin_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            position_reg <= position_next;
            sat_reg      <= sat_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.position       = position_reg;
    assign result.turn_saturated = sat_reg;

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sample.op == OP_SET_ORIGIN |=> result.position == '0)
        else $error("origin word did not give zero position");

    a_sat_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> result.turn_saturated == ((turn_reg == TURN_MAX) ||
                                                    (turn_reg == TURN_MIN)))
        else $error("saturation flag out of step with turn count");

    a_zero_latch: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sample.op == OP_SAMPLE |=> zero_taken_reg)
        else $error("zero angle not latched by sample");

    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (turn_reg == $past(turn_reg)) ||
                 (turn_reg == $past(turn_reg) + TURN_BITS'(1)) ||
                 (turn_reg == $past(turn_reg) - TURN_BITS'(1)))
        else $error("turn count moved by more than one");

endmodule

/* test/mtat_checker.sv */
`timescale 1ns / 1ps

module mtat_checker
    import mtat_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    input  logic                       sample_ready,
    input  logic                       sample_op,
    input  logic [RAW_BITS-1:0]        sample_raw_angle,
    input  logic                       result_valid,
    input  logic                       result_ready,
    input  logic signed [POS_BITS-1:0] result_position,
    input  logic                       result_turn_saturated,
    output int                         mismatch_count,
    output int                         pending_words
);

    localparam int    QUARTER   = 1 << (ANGLE_BITS - 2);
    localparam longint REV_COUNT = longint'(1) << ANGLE_BITS;

    typedef struct {
        logic signed [POS_BITS-1:0] position;
        logic                       turn_saturated;
    } position_word_t;

    position_word_t expected_positions[$];
    position_word_t next_word;
    position_word_t got_word;

    logic [ANGLE_BITS-1:0]       zero_angle;
    logic                        zero_taken;
    zone_t                       prev_zone;
    logic signed [TURN_BITS-1:0] turn_count;
    logic signed [POS_BITS-1:0]  abs_pos;
    logic signed [POS_BITS-1:0]  origin_pos;

    task automatic track_word(input logic op, input logic [RAW_BITS-1:0] raw,
                              output position_word_t w);
        logic [ANGLE_BITS-1:0] angle;
        logic [ANGLE_BITS-1:0] offset;
        zone_t                 zone;
        longint                full;
        angle = raw[ANGLE_BITS-1:0];
        if (op == OP_SET_ORIGIN)
        begin
            origin_pos = abs_pos;
            w.position = '0;
        end
        else
        begin
            if (!zero_taken)
            begin
                zero_angle = angle;
                zero_taken = 1'b1;
            end
            offset = angle - zero_angle;
            if (offset < QUARTER)
                zone = ZONE_LOW;
            else if (offset < 3 * QUARTER)
                zone = ZONE_MID;
            else
                zone = ZONE_HIGH;
            if (prev_zone == ZONE_HIGH && zone == ZONE_LOW && turn_count != TURN_MAX)
                turn_count = turn_count + TURN_BITS'(1);
            else if (prev_zone == ZONE_LOW && zone == ZONE_HIGH && turn_count != TURN_MIN)
                turn_count = turn_count - TURN_BITS'(1);
            prev_zone = zone;
            full = turn_count;
            full = full * REV_COUNT + longint'(offset);
            abs_pos = full[POS_BITS-1:0];
            w.position = abs_pos - origin_pos;
        end
        w.turn_saturated = (turn_count == TURN_MAX) || (turn_count == TURN_MIN);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_angle = '0;
            zero_taken = 1'b0;
            prev_zone  = ZONE_LOW;
            turn_count = '0;
            abs_pos    = '0;
            origin_pos = '0;
            expected_positions.delete();
            pending_words = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                got_word.position       = result_position;
                got_word.turn_saturated = result_turn_saturated;
                if (expected_positions.size() == 0)
                begin
                    $display("%0t: unexpected result word: position %0d saturated %0b",
                             $time, got_word.position, got_word.turn_saturated);
                    mismatch_count++;
                end
                else
                begin
                    next_word = expected_positions.pop_front();
                    if (got_word.position !== next_word.position)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, next_word.position, got_word.position);
                        mismatch_count++;
                    end
                    if (got_word.turn_saturated !== next_word.turn_saturated)
                    begin
                        $display("%0t: turn_saturated expected %0b actual %0b",
                                 $time, next_word.turn_saturated, got_word.turn_saturated);
                        mismatch_count++;
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                track_word(sample_op, sample_raw_angle, next_word);
                expected_positions.push_back(next_word);
            end
            pending_words = expected_positions.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import mtat_pkg::*;

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int REV     = 1 << ANGLE_BITS;

    logic clk;
    logic rst_n;

    mtat_in_if  sample_if ();
    mtat_out_if result_if ();

    multi_turn_angle_tracker_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    int mismatch_count;
    int pending_words;

    mtat_checker chk (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .sample_valid          (sample_if.valid),
        .sample_ready          (sample_if.ready),
        .sample_op             (sample_if.op),
        .sample_raw_angle      (sample_if.raw_angle),
        .result_valid          (result_if.valid),
        .result_ready          (result_if.ready),
        .result_position       (result_if.position),
        .result_turn_saturated (result_if.turn_saturated),
        .mismatch_count        (mismatch_count),
        .pending_words         (pending_words)
    );

    bit                  tx_gaps_on;
    bit                  rx_gaps_on;
    int                  hold_requests;
    int                  words_sent;
    int                  origin_words;
    logic [RAW_BITS-1:0] zero_ref;
    logic [RAW_BITS-1:0] drift_angle;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic send_word(input op_t op, input logic [RAW_BITS-1:0] raw);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid     <= 1'b1;
        sample_if.op        <= op;
        sample_if.raw_angle <= raw;
        do
            @(posedge clk);
        while (!sample_if.ready);
        words_sent++;
        if (op == OP_SET_ORIGIN)
            origin_words++;
        @(negedge clk);
    endtask

    task automatic send_offset(input int offset);
        send_word(OP_SAMPLE, zero_ref + RAW_BITS'(offset));
    endtask

    // forward: high zone then low zone adds a turn; reverse removes one
    task automatic spin_turns(input int turns, input bit forward);
        repeat (turns)
        begin
            if (forward)
            begin
                send_offset($urandom_range(3 * QUARTER, REV - 1));
                send_offset($urandom_range(0, QUARTER - 1));
            end
            else
            begin
                send_offset($urandom_range(0, QUARTER - 1));
                send_offset($urandom_range(3 * QUARTER, REV - 1));
            end
        end
    endtask

    task automatic random_word();
        int pick;
        int step;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send_word(OP_SET_ORIGIN, RAW_BITS'($urandom));
        else if (pick < 18)
            send_word(OP_SAMPLE, RAW_BITS'($urandom));
        else
        begin
            if (pick < 24)
                step = $urandom_range(0, REV - 1);
            else
                step = int'($urandom_range(0, 1400)) - 700;
            drift_angle = drift_angle + RAW_BITS'(step);
            send_word(OP_SAMPLE, zero_ref + drift_angle);
        end
    endtask

    initial
    begin
        int hold_left;
        int idle_left;
        int hold_served;
        hold_left   = 0;
        idle_left   = 0;
        hold_served = 0;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = 59;
                result_if.ready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                result_if.ready <= 1'b0;
                idle_left--;
            end
            else if (rx_gaps_on && $urandom_range(0, 4) == 0)
            begin
                idle_left = $urandom_range(1, 7) - 1;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        sample_if.valid     = 1'b0;
        sample_if.op        = OP_SAMPLE;
        sample_if.raw_angle = '0;
        tx_gaps_on          = 1'b1;
        rx_gaps_on          = 1'b1;
        hold_requests       = 0;
        words_sent          = 0;
        origin_words        = 0;
        zero_ref            = '1;
        drift_angle         = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(OP_SET_ORIGIN, '1);
        send_word(OP_SAMPLE, '1);
        send_offset(1);
        send_offset(QUARTER - 1);
        send_offset(QUARTER);
        send_offset(3 * QUARTER - 1);
        send_offset(3 * QUARTER);
        send_offset(REV - 1);
        send_offset(0);
        send_offset(REV - 1);
        send_offset(REV - 1);
        send_offset(2 * QUARTER);
        send_offset(0);
        send_offset(2 * QUARTER);
        send_offset(3 * QUARTER);
        send_offset(2 * QUARTER);
        send_word(OP_SET_ORIGIN, '0);
        send_offset(3 * QUARTER + 5);
        send_offset(QUARTER - 3);
        send_word(OP_SAMPLE, '0);

        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        spin_turns(12, 1'b1);
        send_word(OP_SET_ORIGIN, '0);
        spin_turns(30, 1'b0);
        send_word(OP_SET_ORIGIN, '1);
        send_offset(3 * QUARTER);

        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        repeat (100) random_word();
        hold_requests++;
        repeat (12) random_word();
        repeat (100) random_word();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        repeat (130) random_word();

        sample_if.valid <= 1'b0;
        wait (pending_words == 0);
        repeat (4) @(posedge clk);
        $display("sent %0d words (%0d origin requests), spun forward and back over many turns",
                 words_sent, origin_words);
        $display("directed zone edges, random drift, noise and a long result stall");
        if (mismatch_count == 0 && pending_words == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #15000000;
        $display("%0t: run timed out", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* multi_turn_angle_tracker_top.f */
hdl/mtat_pkg.sv
hdl/mtat_in_if.sv
hdl/mtat_out_if.sv
hdl/multi_turn_angle_tracker_top.sv
test/mtat_checker.sv
test/tb_top.sv
